### hdl/bqjd_pkg.sv
// Package for the bounded queue job dispatcher.
// Holds field widths, configuration register codes and reset values.
// No dependencies.
package bqjd_pkg;

  localparam int unsigned DurW     = 8;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned CfgTimeW = 11;
  localparam int unsigned CfgCntW  = 5;
  localparam int unsigned WinOutW  = 5;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NUM_WINDOWS    = 2'd0,
    CFG_QUEUE_CAPACITY = 2'd1,
    CFG_OPEN_TIME      = 2'd2,
    CFG_CLOSE_TIME     = 2'd3
  } cfg_idx_e;

  localparam logic [CfgCntW-1:0]  RstNumWindows = 5'd2;
  localparam logic [CfgCntW-1:0]  RstCapacity   = 5'd2;
  localparam logic [CfgTimeW-1:0] RstOpenTime   = 11'(8 * 60);
  localparam logic [CfgTimeW-1:0] RstCloseTime  = 11'(17 * 60);

  localparam logic [TimeW-1:0] TimeMax = '1;

endpackage

### hdl/bounded_queue_job_dispatcher.sv
// Bounded queue job dispatcher: round robin fill of per-window completion FIFOs,
// then earliest-head dispatch through one compare unit. Depends on bqjd_pkg.
// A fill request finds its window by a bit-serial remainder, and a dispatch request by a serial
// head scan. in_stall_o stays high until a request's result is loaded into the output register,
// so the next request waits for it; a result held by out_stall_i delays the next one.
// Reset restores the configuration defaults and clears pointers, occupancy and fill count; the store is never cleared.
module bounded_queue_job_dispatcher import bqjd_pkg::*; #(
  parameter int unsigned MAX_WINDOWS  = 20,
  parameter int unsigned MAX_CAPACITY = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [DurW-1:0]     job_duration_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [TimeW-1:0]    completion_time_o,
  output logic                refused_o,
  output logic [WinOutW-1:0]  window_index_o
);

  localparam int unsigned Depth    = MAX_WINDOWS * MAX_CAPACITY;
  localparam int unsigned AddrW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned WinW     = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int unsigned WinCntW  = $clog2(MAX_WINDOWS + 1);
  localparam int unsigned PtrW     = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
  localparam int unsigned OccW     = $clog2(MAX_CAPACITY + 1);
  localparam int unsigned FcW      = $clog2(Depth + 1);
  localparam int unsigned DivCntW  = (FcW > 1) ? $clog2(FcW) : 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LIMIT, ST_DIV, ST_SCAN, ST_SCAN_END, ST_LAST_RD, ST_UPDATE
  } state_e;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(MAX_CAPACITY - 1)) ? '0 : PtrW'(p + 1'b1);
  endfunction

  function automatic logic [PtrW-1:0] ptr_dec(input logic [PtrW-1:0] p);
    return (p == '0) ? PtrW'(MAX_CAPACITY - 1) : PtrW'(p - 1'b1);
  endfunction

  function automatic logic [AddrW-1:0] mem_addr(input logic [WinW-1:0] w,
                                                 input logic [PtrW-1:0] p);
    return AddrW'(AddrW'(w) * AddrW'(MAX_CAPACITY) + AddrW'(p));
  endfunction

  logic [CfgCntW-1:0]  nwin_cfg_q, cap_cfg_q;
  logic [CfgTimeW-1:0] open_q, close_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nwin_cfg_q <= RstNumWindows;
      cap_cfg_q  <= RstCapacity;
      open_q     <= RstOpenTime;
      close_q    <= RstCloseTime;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NUM_WINDOWS:    nwin_cfg_q <= cfg_data_i[CfgCntW-1:0];
        CFG_QUEUE_CAPACITY: cap_cfg_q  <= cfg_data_i[CfgCntW-1:0];
        CFG_OPEN_TIME:      open_q     <= cfg_data_i[CfgTimeW-1:0];
        CFG_CLOSE_TIME:     close_q    <= cfg_data_i[CfgTimeW-1:0];
        default: ;
      endcase
    end
  end

  logic [WinCntW-1:0] nw_eff;
  logic [OccW-1:0]    cap_eff;

  always_comb begin
    if (nwin_cfg_q == '0) begin
      nw_eff = WinCntW'(1);
    end else if (int'(nwin_cfg_q) > MAX_WINDOWS) begin
      nw_eff = WinCntW'(MAX_WINDOWS);
    end else begin
      nw_eff = WinCntW'(nwin_cfg_q);
    end
    if (cap_cfg_q == '0) begin
      cap_eff = OccW'(1);
    end else if (int'(cap_cfg_q) > MAX_CAPACITY) begin
      cap_eff = OccW'(MAX_CAPACITY);
    end else begin
      cap_eff = OccW'(cap_cfg_q);
    end
  end

  state_e               state_q;
  logic [DurW-1:0]      dur_q;
  logic [WinCntW-1:0]   nw_q;
  logic [OccW-1:0]      cap_q;
  logic [FcW-1:0]       limit_q, fill_q, div_sh_q;
  logic                 fill_ph_q;
  logic [WinCntW-1:0]   rem_q;
  logic [DivCntW-1:0]   div_cnt_q;
  logic [WinW-1:0]      idx_q, pend_idx_q, best_win_q, win_q;
  logic                 pend_q, pend_empty_q;
  logic [TimeW-1:0]     best_key_q;
  logic                 out_valid_q, refused_q;
  logic [TimeW-1:0]     out_time_q;
  logic [WinW-1:0]      out_win_q;

  logic [PtrW-1:0] head_q [MAX_WINDOWS];
  logic [PtrW-1:0] tail_q [MAX_WINDOWS];
  logic [OccW-1:0] occ_q  [MAX_WINDOWS];

  logic [TimeW-1:0] mem [Depth];
  logic [TimeW-1:0] rd_q;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic             wr_en;

  logic [FcW-1:0]     limit_now;
  logic [WinCntW:0]   rem_sh, rem_next;
  logic [TimeW-1:0]   key;
  logic               take;
  logic [WinW-1:0]    cand_win;
  logic               scan_last;
  logic               slot_free;
  logic [PtrW-1:0]    h_cur, t_cur, h1, h2;
  logic [OccW-1:0]    o_cur, o1, o2;
  logic               pop1, pop2;
  logic [FcW-1:0]     fill_post;
  logic [TimeW-1:0]   start;
  logic [TimeW:0]     sum;
  logic [TimeW-1:0]   done;

  always_comb begin
    limit_now = FcW'(nw_q) * FcW'(cap_q);
    rem_sh    = {rem_q, div_sh_q[FcW-1]};
    rem_next  = (rem_sh >= {1'b0, nw_q}) ? rem_sh - {1'b0, nw_q} : rem_sh;
    key       = pend_empty_q ? '0 : rd_q;
    take      = (pend_idx_q == '0) || (key < best_key_q);
    cand_win  = take ? pend_idx_q : best_win_q;
    scan_last = (WinCntW'(idx_q) == nw_q - WinCntW'(1));
    slot_free = !out_valid_q || !out_stall_i;

    h_cur = head_q[win_q];
    t_cur = tail_q[win_q];
    o_cur = occ_q[win_q];
    fill_post = fill_ph_q ? FcW'(fill_q + 1'b1) : fill_q;
    pop1 = (fill_post >= limit_q) && (o_cur >= cap_q);
    h1   = pop1 ? ptr_inc(h_cur) : h_cur;
    o1   = pop1 ? OccW'(o_cur - 1'b1) : o_cur;
    pop2 = (o1 >= OccW'(MAX_CAPACITY));
    h2   = pop2 ? ptr_inc(h1) : h1;
    o2   = pop2 ? OccW'(o1 - 1'b1) : o1;

    start = (o_cur != '0) ? rd_q : TimeW'(open_q);
    sum   = {1'b0, start} + (TimeW + 1)'(dur_q);
    done  = sum[TimeW] ? TimeMax : sum[TimeW-1:0];

    if (state_q == ST_SCAN) begin
      rd_addr = mem_addr(idx_q, head_q[idx_q]);
    end else begin
      rd_addr = mem_addr(win_q, ptr_dec(t_cur));
    end
    wr_addr = mem_addr(win_q, t_cur);
    wr_en   = (state_q == ST_UPDATE) && slot_free;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= done;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_WINDOWS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        occ_q[i]  <= '0;
      end
    end else if (wr_en) begin
      head_q[win_q] <= h2;
      tail_q[win_q] <= ptr_inc(t_cur);
      occ_q[win_q]  <= OccW'(o2 + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      fill_q       <= '0;
      fill_ph_q    <= 1'b0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      dur_q        <= '0;
      nw_q         <= '0;
      cap_q        <= '0;
      limit_q      <= '0;
      div_sh_q     <= '0;
      rem_q        <= '0;
      div_cnt_q    <= '0;
      idx_q        <= '0;
      pend_idx_q   <= '0;
      pend_empty_q <= 1'b0;
      best_win_q   <= '0;
      best_key_q   <= '0;
      win_q        <= '0;
      out_time_q   <= '0;
      refused_q    <= 1'b0;
      out_win_q    <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_UPDATE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            dur_q   <= job_duration_i;
            nw_q    <= nw_eff;
            cap_q   <= cap_eff;
            state_q <= ST_LIMIT;
          end
        end
        ST_LIMIT: begin
          limit_q <= limit_now;
          if (fill_q < limit_now) begin
            fill_ph_q <= 1'b1;
            div_sh_q  <= fill_q;
            rem_q     <= '0;
            div_cnt_q <= '0;
            state_q   <= ST_DIV;
          end else begin
            fill_ph_q <= 1'b0;
            idx_q     <= '0;
            pend_q    <= 1'b0;
            state_q   <= ST_SCAN;
          end
        end
        ST_DIV: begin
          rem_q     <= WinCntW'(rem_next);
          div_sh_q  <= div_sh_q << 1;
          div_cnt_q <= DivCntW'(div_cnt_q + 1'b1);
          if (div_cnt_q == DivCntW'(FcW - 1)) begin
            win_q   <= WinW'(rem_next);
            state_q <= ST_LAST_RD;
          end
        end
        ST_SCAN: begin
          if (pend_q && take) begin
            best_key_q <= key;
            best_win_q <= pend_idx_q;
          end
          pend_q       <= 1'b1;
          pend_idx_q   <= idx_q;
          pend_empty_q <= (occ_q[idx_q] == '0);
          if (scan_last) begin
            state_q <= ST_SCAN_END;
          end else begin
            idx_q <= WinW'(idx_q + 1'b1);
          end
        end
        ST_SCAN_END: begin
          win_q   <= cand_win;
          state_q <= ST_LAST_RD;
        end
        ST_LAST_RD: begin
          state_q <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (slot_free) begin
            fill_q      <= fill_post;
            out_valid_q <= 1'b1;
            out_time_q  <= done;
            refused_q   <= (start >= TimeW'(close_q));
            out_win_q   <= win_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign completion_time_o = out_time_q;
  assign refused_o         = refused_q;
  assign window_index_o    = WinOutW'(out_win_q);

  a_fill_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && fill_ph_q) |-> (fill_q < limit_q))
    else $error("fill request issued with fill count at its limit");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && slot_free) |=> (out_valid_o && state_q == ST_IDLE))
    else $error("completed request did not reach the output register");

  a_window_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |-> (WinCntW'(win_q) < nw_q))
    else $error("request assigned to a window beyond the active count");

  a_occ_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |-> (o_cur <= OccW'(MAX_CAPACITY)))
    else $error("window queue occupancy above its storage");

endmodule

### dv/bounded_queue_job_dispatcher_tb.sv
// Self-checking testbench for the bounded queue job dispatcher: it sends job requests,
// writes the registers between phases, predicts each dispatch and checks every result.
// Depends on bqjd_pkg and bounded_queue_job_dispatcher.
module bounded_queue_job_dispatcher_tb;
  import bqjd_pkg::*;

  localparam int unsigned MaxWindows  = 20;
  localparam int unsigned MaxCapacity = 16;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned MaxReport   = 10;

  typedef struct packed {
    logic [TimeW-1:0]   completion;
    logic               refused;
    logic [WinOutW-1:0] window;
  } job_result_t;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                cfg_we         = 1'b0;
  cfg_idx_e            cfg_idx        = CFG_NUM_WINDOWS;
  logic [CfgDataW-1:0] cfg_data       = '0;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic [DurW-1:0]     job_duration   = '0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic [TimeW-1:0]    res_completion;
  logic                res_refused;
  logic [WinOutW-1:0]  res_window;

  bounded_queue_job_dispatcher #(
    .MAX_WINDOWS (MaxWindows),
    .MAX_CAPACITY(MaxCapacity)
  ) dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .job_duration_i   (job_duration),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .completion_time_o(res_completion),
    .refused_o        (res_refused),
    .window_index_o   (res_window)
  );

  // Predicted state of the window queues and the registers.
  logic [TimeW-1:0]    win_fifo  [MaxWindows][MaxCapacity];
  int unsigned         win_head  [MaxWindows] = '{default: 0};
  int unsigned         win_tail  [MaxWindows] = '{default: 0};
  int unsigned         win_count [MaxWindows] = '{default: 0};
  int unsigned         jobs_filled  = 0;
  logic [CfgCntW-1:0]  cur_windows  = RstNumWindows;
  logic [CfgCntW-1:0]  cur_capacity = RstCapacity;
  logic [CfgTimeW-1:0] cur_open     = RstOpenTime;
  logic [CfgTimeW-1:0] cur_close    = RstCloseTime;

  job_result_t awaited_results [$];
  int unsigned mismatches   = 0;
  bit          send_burst   = 1'b0;
  bit          recv_burst   = 1'b0;
  int unsigned hold_request = 0;

  initial begin : clock_gen
    forever #6 clk = ~clk;
  end

  function automatic int unsigned clamp_count(input logic [CfgCntW-1:0] value,
                                              input int unsigned ceiling);
    if (value == 0) return 1;
    if (value > ceiling) return ceiling;
    return value;
  endfunction

  function automatic void drop_oldest(input int unsigned w);
    if (win_count[w] != 0) begin
      win_head[w] = (win_head[w] + 1) % MaxCapacity;
      win_count[w]--;
    end
  endfunction

  function automatic job_result_t dispatch_job(input logic [DurW-1:0] duration);
    int unsigned windows, capacity, limit, w, i, key, best_key, start_min, done_min;
    job_result_t res;
    windows  = clamp_count(cur_windows, MaxWindows);
    capacity = clamp_count(cur_capacity, MaxCapacity);
    limit    = windows * capacity;
    w        = 0;
    if (jobs_filled < limit) begin
      w = jobs_filled % windows;
      jobs_filled++;
    end else begin
      best_key = 32'hFFFF_FFFF;
      for (i = 0; i < windows; i++) begin
        key = (win_count[i] != 0) ? win_fifo[i][win_head[i]] : 0;
        if (key < best_key) begin
          best_key = key;
          w = i;
        end
      end
    end
    start_min = (win_count[w] != 0) ?
                win_fifo[w][(win_tail[w] + MaxCapacity - 1) % MaxCapacity] : cur_open;
    done_min = start_min + duration;
    if (done_min > TimeMax) done_min = TimeMax;
    if (jobs_filled >= limit && win_count[w] >= capacity) drop_oldest(w);
    if (win_count[w] >= MaxCapacity) drop_oldest(w);
    win_fifo[w][win_tail[w]] = TimeW'(done_min);
    win_tail[w] = (win_tail[w] + 1) % MaxCapacity;
    win_count[w]++;
    res.completion = TimeW'(done_min);
    res.refused    = (start_min >= cur_close);
    res.window     = WinOutW'(w);
    return res;
  endfunction

  function automatic logic [DurW-1:0] pick_duration();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return DurW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CfgCntW-1:0] pick_count(input int unsigned ceiling);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CfgCntW'(1);
      2: return CfgCntW'(ceiling);
      3: return CfgCntW'($urandom_range(ceiling + 1, 31));
      default: return CfgCntW'($urandom_range(1, ceiling));
    endcase
  endfunction

  function automatic logic [CfgTimeW-1:0] pick_minute();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CfgTimeW'(1439);
      2: return '1;
      3: return CfgTimeW'($urandom_range(0, 2047));
      default: return CfgTimeW'($urandom_range(0, 1439));
    endcase
  endfunction

  task automatic send_job(input logic [DurW-1:0] duration);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    job_duration <= duration;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    awaited_results.push_back(dispatch_job(duration));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [CfgCntW-1:0] windows, capacity,
                              input logic [CfgTimeW-1:0] open_min, close_min);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_NUM_WINDOWS;
    cfg_data <= CfgDataW'(windows);
    @(posedge clk);
    cfg_idx  <= CFG_QUEUE_CAPACITY;
    cfg_data <= CfgDataW'(capacity);
    @(posedge clk);
    cfg_idx  <= CFG_OPEN_TIME;
    cfg_data <= CfgDataW'(open_min);
    @(posedge clk);
    cfg_idx  <= CFG_CLOSE_TIME;
    cfg_data <= CfgDataW'(close_min);
    @(posedge clk);
    cfg_we       <= 1'b0;
    cur_windows  = windows;
    cur_capacity = capacity;
    cur_open     = open_min;
    cur_close    = close_min;
  endtask

  task automatic test_reset_config();
    send_job(8'd0);
    send_job(8'd255);
    send_job(8'h55);
    send_job(8'hAA);
    send_job(8'd1);
    send_job(8'd254);
  endtask

  // Zero counts act as one, counts beyond the maximum act as the maximum.
  task automatic test_range_clamp();
    program_regs('0, '0, '0, '0);
    repeat (3) send_job(pick_duration());
    program_regs('1, '1, '1, '1);
    repeat (3) send_job(pick_duration());
  endtask

  // The fill count is already past the limit, so dispatch starts with some windows still empty.
  task automatic test_empty_window();
    program_regs(CfgCntW'(4), CfgCntW'(1), CfgTimeW'(120), CfgTimeW'(700));
    repeat (3) send_job(pick_duration());
  endtask

  // A full queue that is still in the fill phase drops its oldest entry.
  task automatic test_full_queue_fill();
    program_regs(CfgCntW'(1), CfgCntW'(16), CfgTimeW'(600), CfgTimeW'(1200));
    repeat (20) send_job(pick_duration());
    program_regs(CfgCntW'(2), CfgCntW'(16), CfgTimeW'(600), CfgTimeW'(1200));
    repeat (6) send_job(pick_duration());
  endtask

  // The receiver holds off long enough for requests to back up at the input.
  task automatic test_output_hold();
    program_regs(CfgCntW'(3), CfgCntW'(4), CfgTimeW'(300), CfgTimeW'(1439));
    send_burst   = 1'b1;
    hold_request = 250;
    repeat (24) send_job(pick_duration());
    send_burst = 1'b0;
  endtask

  task automatic test_random_phases();
    logic [CfgCntW-1:0]  windows, capacity;
    logic [CfgTimeW-1:0] open_min, close_min;
    repeat (14) begin
      windows   = pick_count(MaxWindows);
      capacity  = pick_count(MaxCapacity);
      open_min  = pick_minute();
      close_min = pick_minute();
      program_regs(windows, capacity, open_min, close_min);
      send_burst = ($urandom_range(0, 3) == 0);
      recv_burst = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(30, 80)) send_job(pick_duration());
    end
    send_burst = 1'b0;
    recv_burst = 1'b0;
  endtask

  // One window chains long jobs until the completion time saturates.
  task automatic test_saturation();
    program_regs(CfgCntW'(1), CfgCntW'(1), '1, CfgTimeW'(1439));
    repeat (300) send_job(DurW'($urandom_range(200, 255)));
  endtask

  initial begin : result_monitor
    int unsigned stall_left, hold_left;
    job_result_t got, want;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.completion = res_completion;
        got.refused    = res_refused;
        got.window     = res_window;
        if (awaited_results.size() == 0) begin
          if (mismatches < MaxReport)
            $display("result with no request pending: completion %0d refused %0b window %0d",
                     got.completion, got.refused, got.window);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (got.completion !== want.completion || got.refused !== want.refused ||
              got.window !== want.window) begin
            if (mismatches < MaxReport)
              $display("dispatch mismatch: expected %0d/%0b/%0d, got %0d/%0b/%0d %s",
                       want.completion, want.refused, want.window,
                       got.completion, got.refused, got.window,
                       "(completion/refused/window)");
            mismatches++;
          end
        end
        stall_left = recv_burst ? 0 : $urandom_range(0, 12);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end else if (hold_left != 0) begin
        hold_left--;
      end
      out_stall <= (stall_left != 0) || (hold_left != 0);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : regression
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_config();
    test_range_clamp();
    test_empty_window();
    test_full_queue_fill();
    test_output_hold();
    test_random_phases();
    test_saturation();
    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### bounded_queue_job_dispatcher.f
hdl/bqjd_pkg.sv
hdl/bounded_queue_job_dispatcher.sv
dv/bounded_queue_job_dispatcher_tb.sv
